[hdl/tnipc_pkg.sv]
package tnipc_pkg;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address 4*index)
   localparam logic [1:0] REG_GRID_COLS     = 2'd0;
   localparam logic [1:0] REG_GRID_ROWS     = 2'd1;
   localparam logic [1:0] REG_DEEPEST_LEVEL = 2'd2;

   // Register reset values
   localparam logic [4:0] RESET_GRID_COLS     = 5'd2;
   localparam logic [4:0] RESET_GRID_ROWS     = 5'd2;
   localparam logic [3:0] RESET_DEEPEST_LEVEL = 4'd4;

   // Request kinds carried in tuser
   localparam logic FUNC_DECODE = 1'b0;
   localparam logic FUNC_ENCODE = 1'b1;

   // Result status carried in tuser
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_ROOT  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // Step counts of the serial units
   localparam logic [3:0] DIV_STEPS   = 4'd8;
   localparam logic [3:0] SPLIT_STEPS = 4'd4;
   localparam logic [3:0] MUL_STEPS   = 4'd9;

   typedef enum logic [15:0] {
      S_IDLE      = 16'h0001,
      S_BLD_INIT  = 16'h0002,
      S_BLD_WR    = 16'h0004,
      S_BLD_MUL   = 16'h0008,
      S_BLD_ADD   = 16'h0010,
      S_DEC_RD0   = 16'h0020,
      S_DEC_CHK   = 16'h0040,
      S_DEC_RD    = 16'h0080,
      S_DEC_LD    = 16'h0100,
      S_DEC_DIV   = 16'h0200,
      S_DEC_SPLIT = 16'h0400,
      S_ENC_RD    = 16'h0800,
      S_ENC_LD    = 16'h1000,
      S_ENC_MUL   = 16'h2000,
      S_ENC_FIN   = 16'h4000,
      S_EMIT      = 16'h8000
   } state_type;

endpackage

[hdl/tree_node_id_path_codec.sv]
// Decode: a table read and a check lead to a root or out-of-range result; else each tree level takes a
// table read, 8 restoring-division steps, 4 column/row split steps and an emit.
// Encode: each path element within the tree depth takes a size table read and a 9-step
// shift-add multiply, and the final element an emit as well. One transaction at a time.
// Reset (synchronous, active high) loads a 2x2 grid and deepest level 4, clears the encode
// accumulator and rebuilds the size table level by level; requests wait until done.
module tree_node_id_path_codec #(
   parameter int MAX_DEPTH = 15,
   parameter int ID_BITS   = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tnipc_pkg::REQ_DATA_W-1:0] req_tdata,  // node_number, step_x, step_y
   input  logic                             req_tuser,  // func
   input  logic                             req_tlast,  // path_end
   // Result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tnipc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_x, out_y, out_level, out_number
   output logic [1:0]                       rsp_tuser,  // status
   output logic                             rsp_tlast,  // last_out
   // Register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tnipc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tnipc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tnipc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   localparam int LW = $clog2(MAX_DEPTH + 1);
   localparam int AW = ID_BITS + 9;
   localparam int DW = ID_BITS + 7;
   localparam logic [ID_BITS-1:0] ID_MASK   = {ID_BITS{1'b1}};
   localparam logic [AW-1:0]      ID_MASK_W = {{9{1'b0}}, ID_MASK};

   tnipc_pkg::state_type state_ff, state_in;

   // Configuration and persistent state
   logic [4:0]         cols_ff, cols_in;
   logic [4:0]         rows_ff, rows_in;
   logic [3:0]         dlev_ff, dlev_in;
   logic               tab_err_ff, tab_err_in;
   logic [ID_BITS-1:0] enc_sum_ff, enc_sum_in;
   logic [3:0]         enc_depth_ff, enc_depth_in;
   logic               enc_err_ff, enc_err_in;
   logic               path_end_ff, path_end_in;

   // Serial datapath
   logic [LW-1:0]      addr_ff, addr_in;
   logic [3:0]         lvl_ff, lvl_in;
   logic [ID_BITS-1:0] rem_ff, rem_in;
   logic [DW-1:0]      dv_ff, dv_in;
   logic [7:0]         quo_ff, quo_in;
   logic [7:0]         sd_ff, sd_in;
   logic [3:0]         y_ff, y_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [AW-1:0]      mc_ff, mc_in;
   logic [8:0]         mq_ff, mq_in;
   logic [AW-1:0]      acc_ff, acc_in;
   logic [ID_BITS-1:0] pw_ff, pw_in;
   logic [ID_BITS-1:0] cap_ff, cap_in;
   logic               sat_ff, sat_in;

   // Staged result and output register
   logic [3:0]  stg_x_ff, stg_x_in;
   logic [3:0]  stg_y_ff, stg_y_in;
   logic [3:0]  stg_lvl_ff, stg_lvl_in;
   logic [31:0] stg_num_ff, stg_num_in;
   logic [1:0]  stg_st_ff, stg_st_in;
   logic        stg_last_ff, stg_last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_x_ff, rsp_x_in;
   logic [3:0]  rsp_y_ff, rsp_y_in;
   logic [3:0]  rsp_lvl_ff, rsp_lvl_in;
   logic [31:0] rsp_num_ff, rsp_num_in;
   logic [1:0]  rsp_st_ff, rsp_st_in;
   logic        rsp_last_ff, rsp_last_in;

   // Derived values
   logic [4:0]         ecols, erows;
   logic [3:0]         top;
   logic [8:0]         grid_m;
   logic [3:0]         req_sx, req_sy;
   logic [8:0]         enc_idx;
   logic               step_bad;
   logic [LW-1:0]      enc_addr;
   logic [ID_BITS-1:0] rd_data;
   logic               tab_wr;
   logic [ID_BITS-1:0] tab_wdata;
   logic               out_free;
   logic               csr_wr;
   logic               div_ge;
   logic [DW-1:0]      div_diff;
   logic               sp_ge;
   logic               fin_err;
   logic [ID_BITS-1:0] fin_sum;
   logic [ID_BITS:0]   bld_sum;

   // Clamp grid size and depth to their usable ranges
   always_comb begin
      ecols = (cols_ff == 5'd0) ? 5'd1 : ((cols_ff > 5'd16) ? 5'd16 : cols_ff);
      erows = (rows_ff == 5'd0) ? 5'd1 : ((rows_ff > 5'd16) ? 5'd16 : rows_ff);
      top   = (32'(dlev_ff) > MAX_DEPTH) ? 4'(MAX_DEPTH) : dlev_ff;
   end

   assign grid_m   = 9'(10'(ecols) * 10'(erows));
   assign req_sx   = req_tdata[35:32];
   assign req_sy   = req_tdata[39:36];
   assign enc_idx  = 9'(9'(ecols) * 9'(req_sy) + 9'(req_sx));
   assign step_bad = ({1'b0, req_sx} >= ecols) || ({1'b0, req_sy} >= erows);
   assign enc_addr = LW'((32'(enc_depth_ff) + 32'd1) & MAX_DEPTH);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Restoring division step and column split step
   assign div_ge   = DW'(rem_ff) >= dv_ff;
   assign div_diff = DW'(rem_ff) - dv_ff;
   assign sp_ge    = quo_ff >= sd_ff;

   // Encode accumulate and table build add
   assign fin_err = enc_err_ff || (acc_ff >= ID_MASK_W);
   assign fin_sum = enc_sum_ff + acc_ff[ID_BITS-1:0] + ID_BITS'(1);
   assign bld_sum = {1'b0, cap_ff} + {1'b0, acc_ff[ID_BITS-1:0]};

   // Subtree size table
   assign tab_wr    = (state_ff == tnipc_pkg::S_BLD_WR);
   assign tab_wdata = sat_ff ? ID_MASK : cap_ff;

   tnipc_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (MAX_DEPTH + 1)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (tab_wr),
      .wr_addr (addr_ff),
      .wr_data (tab_wdata),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      dlev_in      = dlev_ff;
      tab_err_in   = tab_err_ff;
      enc_sum_in   = enc_sum_ff;
      enc_depth_in = enc_depth_ff;
      enc_err_in   = enc_err_ff;
      path_end_in  = path_end_ff;
      addr_in      = addr_ff;
      lvl_in       = lvl_ff;
      rem_in       = rem_ff;
      dv_in        = dv_ff;
      quo_in       = quo_ff;
      sd_in        = sd_ff;
      y_in         = y_ff;
      cnt_in       = cnt_ff;
      mc_in        = mc_ff;
      mq_in        = mq_ff;
      acc_in       = acc_ff;
      pw_in        = pw_ff;
      cap_in       = cap_ff;
      sat_in       = sat_ff;
      stg_x_in     = stg_x_ff;
      stg_y_in     = stg_y_ff;
      stg_lvl_in   = stg_lvl_ff;
      stg_num_in   = stg_num_ff;
      stg_st_in    = stg_st_ff;
      stg_last_in  = stg_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         tnipc_pkg::S_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  tnipc_pkg::FUNC_DECODE: begin
                     rem_in   = ID_BITS'(req_tdata[31:0]);
                     addr_in  = '0;
                     state_in = tnipc_pkg::S_DEC_RD0;
                  end
                  tnipc_pkg::FUNC_ENCODE: begin
                     path_end_in = req_tlast;
                     if (enc_depth_ff >= top) begin
                        // Path deeper than the tree: flag and do not count
                        enc_err_in = 1'b1;
                        if (req_tlast) begin
                           stg_x_in     = '0;
                           stg_y_in     = '0;
                           stg_lvl_in   = enc_depth_ff;
                           stg_num_in   = '0;
                           stg_st_in    = tnipc_pkg::STATUS_RANGE;
                           stg_last_in  = 1'b1;
                           enc_sum_in   = '0;
                           enc_depth_in = '0;
                           enc_err_in   = 1'b0;
                           state_in     = tnipc_pkg::S_EMIT;
                        end
                     end else begin
                        enc_depth_in = enc_depth_ff + 4'd1;
                        enc_err_in   = enc_err_ff || step_bad;
                        mq_in        = enc_idx;
                        addr_in      = enc_addr;
                        state_in     = tnipc_pkg::S_ENC_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         tnipc_pkg::S_DEC_RD0: begin
            state_in = tnipc_pkg::S_DEC_CHK;
         end

         tnipc_pkg::S_DEC_CHK: begin
            stg_x_in    = '0;
            stg_y_in    = '0;
            stg_lvl_in  = '0;
            stg_num_in  = '0;
            stg_last_in = 1'b1;
            if (tab_err_ff || (rem_ff >= rd_data)) begin
               stg_st_in = tnipc_pkg::STATUS_RANGE;
               state_in  = tnipc_pkg::S_EMIT;
            end else if (rem_ff == '0) begin
               stg_st_in = tnipc_pkg::STATUS_ROOT;
               state_in  = tnipc_pkg::S_EMIT;
            end else begin
               rem_in   = rem_ff - ID_BITS'(1);
               lvl_in   = 4'd1;
               addr_in  = LW'(1);
               state_in = tnipc_pkg::S_DEC_RD;
            end
         end

         tnipc_pkg::S_DEC_RD: begin
            state_in = tnipc_pkg::S_DEC_LD;
         end

         tnipc_pkg::S_DEC_LD: begin
            // Align the divisor to the top quotient bit
            dv_in    = {((rd_data == '0) ? ID_BITS'(1) : rd_data), 7'b0};
            quo_in   = '0;
            cnt_in   = '0;
            state_in = tnipc_pkg::S_DEC_DIV;
         end

         tnipc_pkg::S_DEC_DIV: begin
            if (cnt_ff == tnipc_pkg::DIV_STEPS) begin
               sd_in    = {ecols, 3'b0};
               y_in     = '0;
               cnt_in   = '0;
               state_in = tnipc_pkg::S_DEC_SPLIT;
            end else begin
               if (div_ge) begin
                  rem_in = div_diff[ID_BITS-1:0];
               end
               quo_in = {quo_ff[6:0], div_ge};
               dv_in  = dv_ff >> 1;
               cnt_in = cnt_ff + 4'd1;
            end
         end

         tnipc_pkg::S_DEC_SPLIT: begin
            if (cnt_ff == tnipc_pkg::SPLIT_STEPS) begin
               stg_x_in    = quo_ff[3:0];
               stg_y_in    = y_ff;
               stg_lvl_in  = lvl_ff;
               stg_num_in  = '0;
               stg_st_in   = tnipc_pkg::STATUS_OK;
               stg_last_in = (rem_ff == '0) || (lvl_ff == top);
               state_in    = tnipc_pkg::S_EMIT;
            end else begin
               if (sp_ge) begin
                  quo_in = quo_ff - sd_ff;
               end
               y_in   = {y_ff[2:0], sp_ge};
               sd_in  = sd_ff >> 1;
               cnt_in = cnt_ff + 4'd1;
            end
         end

         tnipc_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = stg_x_ff;
               rsp_y_in     = stg_y_ff;
               rsp_lvl_in   = stg_lvl_ff;
               rsp_num_in   = stg_num_ff;
               rsp_st_in    = stg_st_ff;
               rsp_last_in  = stg_last_ff;
               if (stg_last_ff) begin
                  state_in = tnipc_pkg::S_IDLE;
               end else begin
                  // Descend one level
                  rem_in   = rem_ff - ID_BITS'(1);
                  lvl_in   = lvl_ff + 4'd1;
                  addr_in  = LW'(lvl_ff + 4'd1);
                  state_in = tnipc_pkg::S_DEC_RD;
               end
            end
         end

         tnipc_pkg::S_ENC_RD: begin
            state_in = tnipc_pkg::S_ENC_LD;
         end

         tnipc_pkg::S_ENC_LD: begin
            mc_in    = AW'(rd_data);
            acc_in   = '0;
            cnt_in   = '0;
            state_in = tnipc_pkg::S_ENC_MUL;
         end

         tnipc_pkg::S_ENC_MUL, tnipc_pkg::S_BLD_MUL: begin
            if (cnt_ff == tnipc_pkg::MUL_STEPS) begin
               state_in = (state_ff == tnipc_pkg::S_ENC_MUL) ? tnipc_pkg::S_ENC_FIN
                                                             : tnipc_pkg::S_BLD_ADD;
            end else begin
               if (mq_ff[0]) begin
                  acc_in = acc_ff + mc_ff;
               end
               mc_in  = mc_ff << 1;
               mq_in  = mq_ff >> 1;
               cnt_in = cnt_ff + 4'd1;
            end
         end

         tnipc_pkg::S_ENC_FIN: begin
            enc_err_in = fin_err;
            enc_sum_in = fin_sum;
            if (path_end_ff) begin
               stg_x_in     = '0;
               stg_y_in     = '0;
               stg_lvl_in   = enc_depth_ff;
               stg_last_in  = 1'b1;
               if (fin_err || tab_err_ff) begin
                  stg_num_in = '0;
                  stg_st_in  = tnipc_pkg::STATUS_RANGE;
               end else begin
                  stg_num_in = 32'(fin_sum);
                  stg_st_in  = tnipc_pkg::STATUS_OK;
               end
               enc_sum_in   = '0;
               enc_depth_in = '0;
               enc_err_in   = 1'b0;
               state_in     = tnipc_pkg::S_EMIT;
            end else begin
               state_in = tnipc_pkg::S_IDLE;
            end
         end

         tnipc_pkg::S_BLD_INIT: begin
            addr_in  = LW'(top);
            pw_in    = ID_BITS'(1);
            cap_in   = ID_BITS'(1);
            sat_in   = 1'b0;
            state_in = tnipc_pkg::S_BLD_WR;
         end

         tnipc_pkg::S_BLD_WR: begin
            // Entry is written by the RAM port in this state
            if (addr_ff == '0) begin
               tab_err_in = sat_ff;
               state_in   = tnipc_pkg::S_IDLE;
            end else if (sat_ff) begin
               addr_in = addr_ff - LW'(1);
            end else begin
               mc_in    = AW'(pw_ff);
               mq_in    = grid_m;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = tnipc_pkg::S_BLD_MUL;
            end
         end

         tnipc_pkg::S_BLD_ADD: begin
            if (acc_ff[AW-1:ID_BITS] != '0) begin
               sat_in = 1'b1;
            end else begin
               pw_in = acc_ff[ID_BITS-1:0];
               if (bld_sum[ID_BITS]) begin
                  sat_in = 1'b1;
               end else begin
                  cap_in = bld_sum[ID_BITS-1:0];
               end
            end
            addr_in  = addr_ff - LW'(1);
            state_in = tnipc_pkg::S_BLD_WR;
         end

         default: begin
            state_in = tnipc_pkg::S_BLD_INIT;
         end
      endcase

      // Register write: update, drop the encode accumulator and rebuild the table
      if (csr_wr) begin
         case (csr_paddr[3:2])
            tnipc_pkg::REG_GRID_COLS: begin
               cols_in  = csr_pwdata[4:0];
               state_in = tnipc_pkg::S_BLD_INIT;
            end
            tnipc_pkg::REG_GRID_ROWS: begin
               rows_in  = csr_pwdata[4:0];
               state_in = tnipc_pkg::S_BLD_INIT;
            end
            tnipc_pkg::REG_DEEPEST_LEVEL: begin
               dlev_in  = csr_pwdata[3:0];
               state_in = tnipc_pkg::S_BLD_INIT;
            end
            default: ;
         endcase
         if (state_in == tnipc_pkg::S_BLD_INIT) begin
            enc_sum_in   = '0;
            enc_depth_in = '0;
            enc_err_in   = 1'b0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tnipc_pkg::S_BLD_INIT;
         cols_ff      <= tnipc_pkg::RESET_GRID_COLS;
         rows_ff      <= tnipc_pkg::RESET_GRID_ROWS;
         dlev_ff      <= tnipc_pkg::RESET_DEEPEST_LEVEL;
         tab_err_ff   <= 1'b0;
         enc_sum_ff   <= '0;
         enc_depth_ff <= '0;
         enc_err_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         dlev_ff      <= dlev_in;
         tab_err_ff   <= tab_err_in;
         enc_sum_ff   <= enc_sum_in;
         enc_depth_ff <= enc_depth_in;
         enc_err_ff   <= enc_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and payload
   always_ff @(posedge clock) begin
      path_end_ff <= path_end_in;
      addr_ff     <= addr_in;
      lvl_ff      <= lvl_in;
      rem_ff      <= rem_in;
      dv_ff       <= dv_in;
      quo_ff      <= quo_in;
      sd_ff       <= sd_in;
      y_ff        <= y_in;
      cnt_ff      <= cnt_in;
      mc_ff       <= mc_in;
      mq_ff       <= mq_in;
      acc_ff      <= acc_in;
      pw_ff       <= pw_in;
      cap_ff      <= cap_in;
      sat_ff      <= sat_in;
      stg_x_ff    <= stg_x_in;
      stg_y_ff    <= stg_y_in;
      stg_lvl_ff  <= stg_lvl_in;
      stg_num_ff  <= stg_num_in;
      stg_st_ff   <= stg_st_in;
      stg_last_ff <= stg_last_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_lvl_ff  <= rsp_lvl_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Register readback
   always_comb begin
      case (csr_paddr[3:2])
         tnipc_pkg::REG_GRID_COLS:     csr_prdata = {27'b0, cols_ff};
         tnipc_pkg::REG_GRID_ROWS:     csr_prdata = {27'b0, rows_ff};
         tnipc_pkg::REG_DEEPEST_LEVEL: csr_prdata = {28'b0, dlev_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == tnipc_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_num_ff, rsp_lvl_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hdl/tnipc_ram.sv]
module tnipc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, read one entry through the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
